// ----- rtl/lars_pkg.sv -----
// ----------------------------------------------------------------------------
// lars_pkg
// Shared types and constants for the life automaton row stepper.
// ----------------------------------------------------------------------------
package lars_pkg;

  localparam int ROW_W       = 64;
  localparam int GW_W        = 7;
  localparam logic [GW_W-1:0] GRID_WIDTH_RST = 7'd30;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = 3;

  typedef struct packed {
    logic [ROW_W-1:0] next_row_cells;
    logic             frame_done;
  } out_item_t;

  typedef struct packed {
    logic      push_a;
    out_item_t item_a;
    logic      push_b;
    out_item_t item_b;
  } fifo_push_t;

endpackage

// ----- rtl/lars_if.sv -----
// ----------------------------------------------------------------------------
// lars_if
// Channel interfaces: row input, result output, width configuration.
// ----------------------------------------------------------------------------
interface lars_in_if import lars_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_cells;
  logic             first_row;
  logic             last_row;

  modport source (output valid, output row_cells, output first_row, output last_row,
                  input ready);
  modport sink   (input valid, input row_cells, input first_row, input last_row,
                  output ready);
endinterface

interface lars_out_if import lars_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] next_row_cells;
  logic             frame_done;

  modport source (output valid, output next_row_cells, output frame_done, input ready);
  modport sink   (input valid, input next_row_cells, input frame_done, output ready);
endinterface

interface lars_cfg_if import lars_pkg::*;;
  logic            valid;
  logic            ready;
  logic [GW_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/life_automaton_row_stepper_unit.sv -----
// ----------------------------------------------------------------------------
// life_automaton_row_stepper_unit
// B3/S23 row stepper on a non-wrapping grid, one row of cells per item.
// ----------------------------------------------------------------------------
// channel  | dir | payload
// in_ch    | in  | row_cells[63:0], first_row, last_row
// out_ch   | out | next_row_cells[63:0], frame_done
// cfg_ch   | in  | data[6:0] = grid_width
//
// One row item per cycle while in_ch is ready; every column has its own lane,
// two lane rows evaluate the held row and, on the last row, the bottom row in
// the same cycle. Results lag the input by one row and go through a 4-entry
// queue; in_ch is ready while the queue has room for two items.
// Sync active-low reset empties the row state and queue, grid_width = 30.
// ----------------------------------------------------------------------------
module life_automaton_row_stepper_unit import lars_pkg::*; #(
  parameter int MAX_WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  lars_in_if.sink    in_ch,
  lars_out_if.source out_ch,
  lars_cfg_if.sink   cfg_ch
);

  logic [GW_W-1:0]      grid_width_r;
  logic [MAX_WIDTH-1:0] row_above_r, row_above_nxt;
  logic [MAX_WIDTH-1:0] row_middle_r, row_middle_nxt;
  logic                 middle_valid_r, middle_valid_nxt;

  logic [MAX_WIDTH-1:0] mask;
  logic [MAX_WIDTH-1:0] cur;
  logic [MAX_WIDTH-1:0] eff_above;
  logic [MAX_WIDTH-1:0] eff_mid;
  logic [MAX_WIDTH-1:0] new_above;
  logic [MAX_WIDTH-1:0] gen_a;
  logic [MAX_WIDTH-1:0] gen_b;
  logic                 eff_valid;
  logic                 accept;
  logic                 space2;
  fifo_push_t           push;

  for (genvar j = 0; j < MAX_WIDTH; j++) begin : g_mask
    assign mask[j] = (grid_width_r > GW_W'(j));
  end

  assign accept    = in_ch.valid && in_ch.ready;
  assign cur       = in_ch.row_cells[MAX_WIDTH-1:0] & mask;
  assign eff_valid = middle_valid_r && !in_ch.first_row;
  assign eff_above = in_ch.first_row ? '0 : row_above_r;
  assign eff_mid   = in_ch.first_row ? '0 : row_middle_r;
  assign new_above = eff_valid ? eff_mid : '0;

  lars_row_gen #(.W(MAX_WIDTH)) u_gen_a (
    .up   (eff_above),
    .mid  (eff_mid),
    .dn   (cur),
    .mask (mask),
    .nxt  (gen_a)
  );

  // bottom row: dead row below
  lars_row_gen #(.W(MAX_WIDTH)) u_gen_b (
    .up   (new_above),
    .mid  (cur),
    .dn   ('0),
    .mask (mask),
    .nxt  (gen_b)
  );

  always_comb begin
    row_above_nxt    = row_above_r;
    row_middle_nxt   = row_middle_r;
    middle_valid_nxt = middle_valid_r;
    if (accept) begin
      if (in_ch.last_row) begin
        row_above_nxt    = '0;
        row_middle_nxt   = '0;
        middle_valid_nxt = 1'b0;
      end else begin
        row_above_nxt    = new_above;
        row_middle_nxt   = cur;
        middle_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r   <= GRID_WIDTH_RST;
      row_above_r    <= '0;
      row_middle_r   <= '0;
      middle_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        grid_width_r <= cfg_ch.data;
      end
      row_above_r    <= row_above_nxt;
      row_middle_r   <= row_middle_nxt;
      middle_valid_r <= middle_valid_nxt;
    end
  end

  assign push.push_a                = accept && eff_valid;
  assign push.item_a.next_row_cells = ROW_W'(gen_a);
  assign push.item_a.frame_done     = 1'b0;
  assign push.push_b                = accept && in_ch.last_row;
  assign push.item_b.next_row_cells = ROW_W'(gen_b);
  assign push.item_b.frame_done     = 1'b1;

  lars_out_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .space2 (space2),
    .out_ch (out_ch)
  );

  assign in_ch.ready  = space2;
  assign cfg_ch.ready = 1'b1;

endmodule

// ----- rtl/lars_lane.sv -----
// ----------------------------------------------------------------------------
// lars_lane
// One cell of the B3/S23 rule from its 3x3 neighborhood.
// ----------------------------------------------------------------------------
module lars_lane (
  input  logic [2:0] up,
  input  logic [2:0] mid,
  input  logic [2:0] dn,
  input  logic       en,
  output logic       alive
);

  logic [3:0] n;

  assign n = 4'(up[0]) + 4'(up[1]) + 4'(up[2])
           + 4'(mid[0]) + 4'(mid[2])
           + 4'(dn[0]) + 4'(dn[1]) + 4'(dn[2]);

  assign alive = en && ((n == 4'd3) || (mid[1] && (n == 4'd2)));

endmodule

// ----- rtl/lars_row_gen.sv -----
// ----------------------------------------------------------------------------
// lars_row_gen
// One lane per column; merges lane outputs into the next-generation row.
// ----------------------------------------------------------------------------
module lars_row_gen #(
  parameter int W = 64
) (
  input  logic [W-1:0] up,
  input  logic [W-1:0] mid,
  input  logic [W-1:0] dn,
  input  logic [W-1:0] mask,
  output logic [W-1:0] nxt
);

  logic [W+1:0] up_p;
  logic [W+1:0] mid_p;
  logic [W+1:0] dn_p;
  logic [W-1:0] lane_out;

  // pad one dead column at each edge
  assign up_p  = {1'b0, up  & mask, 1'b0};
  assign mid_p = {1'b0, mid & mask, 1'b0};
  assign dn_p  = {1'b0, dn  & mask, 1'b0};

  for (genvar j = 0; j < W; j++) begin : g_lane
    lars_lane u_lane (
      .up    (up_p[j+2:j]),
      .mid   (mid_p[j+2:j]),
      .dn    (dn_p[j+2:j]),
      .en    (mask[j]),
      .alive (lane_out[j])
    );
  end

  assign nxt = lane_out;

endmodule

// ----- rtl/lars_out_fifo.sv -----
// ----------------------------------------------------------------------------
// lars_out_fifo
// Four-entry result queue taking up to two items per cycle.
// ----------------------------------------------------------------------------
module lars_out_fifo import lars_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  fifo_push_t push,
  output logic       space2,
  lars_out_if.source out_ch
);

  out_item_t             mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic [FIFO_PTR_W-1:0] wr_b;
  logic                  pop;

  assign pop    = out_ch.valid && out_ch.ready;
  assign wr_b   = wr_ptr_r + FIFO_PTR_W'(push.push_a);
  assign space2 = (count_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push.push_a) + FIFO_PTR_W'(push.push_b);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
  assign count_nxt  = count_r + FIFO_CNT_W'(push.push_a) + FIFO_CNT_W'(push.push_b)
                    - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.push_a) begin
      mem_r[wr_ptr_r] <= push.item_a;
    end
    if (push.push_b) begin
      mem_r[wr_b] <= push.item_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign out_ch.valid          = (count_r != '0);
  assign out_ch.next_row_cells = mem_r[rd_ptr_r].next_row_cells;
  assign out_ch.frame_done     = mem_r[rd_ptr_r].frame_done;

endmodule

// ----- test/life_automaton_row_stepper_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_automaton_row_stepper_unit_test
// Drives rows of cells through the B3/S23 row stepper and predicts each
// next-generation row in a small scoreboard. It covers directed edge cases,
// then random frames at several grid widths, with random idling on both
// channels and one long output hold-off that fills the result queue.
// ----------------------------------------------------------------------------
module life_automaton_row_stepper_unit_test;
  import lars_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 73;
  localparam int NUM_PHASES    = 11;
  localparam int CYCLE_LIMIT   = 200000;

  class generation_scoreboard;
    logic [GW_W-1:0]  grid_width;
    logic [ROW_W-1:0] row_above;
    logic [ROW_W-1:0] row_middle;
    bit               middle_held;
    out_item_t        pending_rows[$];
    int               mismatches;

    function new();
      grid_width  = GRID_WIDTH_RST;
      row_above   = '0;
      row_middle  = '0;
      middle_held = 0;
      mismatches  = 0;
    endfunction

    function logic [ROW_W-1:0] width_mask();
      int w;
      w = grid_width;
      if (w >= ROW_W) return '1;
      return (64'd1 << w) - 64'd1;
    endfunction

    function logic [ROW_W-1:0] next_cells(logic [ROW_W-1:0] up, logic [ROW_W-1:0] mid,
                                          logic [ROW_W-1:0] down);
      logic [ROW_W-1:0] mask;
      logic [ROW_W-1:0] res;
      logic [ROW_W+1:0] u, m, d;
      int n;
      mask = width_mask();
      res  = '0;
      u = {1'b0, up & mask, 1'b0};
      m = {1'b0, mid & mask, 1'b0};
      d = {1'b0, down & mask, 1'b0};
      for (int j = 0; j < ROW_W; j++) begin
        n = u[j] + u[j+1] + u[j+2] + m[j] + m[j+2] + d[j] + d[j+1] + d[j+2];
        if (mask[j] && ((m[j+1] && (n == 2 || n == 3)) || (!m[j+1] && n == 3)))
          res[j] = 1'b1;
      end
      return res;
    endfunction

    function void note_row(logic [ROW_W-1:0] cells, logic first, logic last);
      logic [ROW_W-1:0] cur;
      out_item_t e;
      cur = cells & width_mask();
      if (first) begin
        middle_held = 0;
        row_above   = '0;
        row_middle  = '0;
      end
      if (middle_held) begin
        e.next_row_cells = next_cells(row_above, row_middle, cur);
        e.frame_done     = 1'b0;
        pending_rows.push_back(e);
        row_above = row_middle;
      end else begin
        row_above = '0;
      end
      row_middle  = cur;
      middle_held = 1;
      if (last) begin
        e.next_row_cells = next_cells(row_above, row_middle, '0);
        e.frame_done     = 1'b1;
        pending_rows.push_back(e);
        row_above   = '0;
        row_middle  = '0;
        middle_held = 0;
      end
    endfunction

    function void check_result(logic [ROW_W-1:0] cells, logic done);
      out_item_t e;
      if (pending_rows.size() == 0) begin
        $error("unexpected result item: next_row_cells %h frame_done %b", cells, done);
        mismatches++;
        return;
      end
      e = pending_rows.pop_front();
      if (cells !== e.next_row_cells) begin
        $error("next_row_cells: expected %h, actual %h", e.next_row_cells, cells);
        mismatches++;
      end
      if (done !== e.frame_done) begin
        $error("frame_done: expected %b, actual %b", e.frame_done, done);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_enable;
  bit   hold_request;
  int   cycle_count;
  int   phase_width[NUM_PHASES];

  generation_scoreboard sb = new();

  lars_in_if  in_ch();
  lars_out_if out_ch();
  lars_cfg_if cfg_ch();

  life_automaton_row_stepper_unit #(.MAX_WIDTH(64)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_row(in_ch.row_cells, in_ch.first_row, in_ch.last_row);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.next_row_cells, out_ch.frame_done);
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 0;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [ROW_W-1:0] rand_row();
    logic [ROW_W-1:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return a & b & {$urandom, $urandom};
      3, 4: return a & b;
      default: return a;
    endcase
  endfunction

  task automatic send_row(logic [ROW_W-1:0] cells, logic first, logic last);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.row_cells <= cells;
    in_ch.first_row <= first;
    in_ch.last_row  <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_rows.size() != 0) @(posedge clk);
  endtask

  task automatic write_width(logic [GW_W-1:0] w);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid    <= 1'b0;
    sb.grid_width = w;
  endtask

  // mostly well-formed frames; some without a bottom, without a top, or noise
  task automatic run_frames(int budget);
    int sent, height, kind;
    sent = 0;
    while (sent < budget) begin
      kind   = $urandom_range(0, 9);
      height = (kind < 6) ? $urandom_range(1, 4) : $urandom_range(1, 10);
      if (kind == 9) begin
        send_row(rand_row(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        for (int r = 0; r < height; r++) begin
          send_row(rand_row(), (kind == 8) ? 1'b0 : (r == 0),
                   (kind == 7) ? 1'b0 : (r == height - 1));
          sent++;
        end
      end
    end
    send_row(rand_row(), 1'b0, 1'b1);
  endtask

  initial begin
    cycle_count     = 0;
    idle_enable     = 1;
    hold_request    = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.row_cells <= '0;
    in_ch.first_row <= 1'b0;
    in_ch.last_row  <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset width: one-row grid, blinker, edge columns, bits above width
    send_row('1, 1'b1, 1'b1);
    send_row(64'h0, 1'b1, 1'b0);
    send_row(64'h70, 1'b0, 1'b0);
    send_row(64'h0, 1'b0, 1'b1);
    // no top row flag on an empty block
    send_row(64'h0000_0000_0000_00e6, 1'b0, 1'b0);
    send_row(64'h0000_0000_0000_0038, 1'b0, 1'b1);
    // restart while a frame is open
    send_row(64'h0000_0000_0000_001c, 1'b1, 1'b0);
    send_row(64'h0000_0000_0000_001c, 1'b0, 1'b0);
    send_row(64'h0000_0000_0000_0007, 1'b1, 1'b0);
    send_row(64'h0000_0000_0000_0007, 1'b0, 1'b1);
    send_row(64'hffff_ffff_e000_0003, 1'b1, 1'b0);
    send_row(64'hf000_0000_3000_0001, 1'b0, 1'b0);
    send_row(64'h0000_0000_3000_0003, 1'b0, 1'b0);
    send_row(64'hffff_ffff_c000_0000, 1'b0, 1'b1);

    write_width(7'd0);
    send_row('1, 1'b1, 1'b0);
    send_row('1, 1'b0, 1'b1);
    write_width(7'd64);
    send_row(64'h8000_0000_0000_0003, 1'b1, 1'b0);
    send_row(64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b0);
    send_row(64'hc000_0000_0000_0001, 1'b0, 1'b1);
    write_width(7'd127);
    send_row('1, 1'b1, 1'b0);
    send_row(64'h5555_5555_5555_5555, 1'b0, 1'b1);
    write_width(7'd1);
    send_row('1, 1'b1, 1'b0);
    send_row('1, 1'b0, 1'b1);

    phase_width = '{64, 1, 2, 127, 0, 3, 63, 65, 17, 30, 30};
    phase_width[8] = $urandom_range(4, 62);
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_width(GW_W'(phase_width[p]));
      if (p == 2) hold_request = 1;
      if (p == NUM_PHASES - 1) idle_enable = 0;
      run_frames(PHASE_ITEMS);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_rows.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
